FILE: hdl/lru_slot_manager_pinned_root_core_defines.svh
// ----------------------------------------------------------------------------
// LRU slot manager assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LRU_SLOT_MANAGER_PINNED_ROOT_CORE_DEFINES_SVH
`define LRU_SLOT_MANAGER_PINNED_ROOT_CORE_DEFINES_SVH

`ifndef SYNTH
// Property that holds at every clock edge outside reset
`define LSM_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next
`define LSM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LSM_ASSERT(name, clk, rst_n, prop, msg)
`define LSM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/lsm_pkg.sv
// ----------------------------------------------------------------------------
// LRU slot manager package
// Widths, command and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package lsm_pkg;

	// Pool geometry
	localparam int SLOT_COUNT = 32;
	localparam int SLOT_W     = 5;
	localparam int COUNT_W    = 6;
	localparam int CMD_W      = 3;
	localparam int STATUS_W   = 3;

	// Stream payload widths
	localparam int IN_DATA_W  = 8;
	localparam int RES_W      = STATUS_W + SLOT_W + 1 + SLOT_W + SLOT_W;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_PAD_W  = OUT_DATA_W - RES_W;

	// Fixed slots
	localparam logic [SLOT_W-1:0] RESERVED_SLOT = 5'd0;
	localparam logic [SLOT_W-1:0] ROOT_SLOT     = 5'd1;

	// Commands
	localparam logic [CMD_W-1:0] CMD_INSERT_ROOT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOCATE    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TOUCH       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RELEASE     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LOOKUP      = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK                = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND         = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_EMPTY         = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_ROOT           = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ROOT_PROTECTED    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOTHING_TO_DELETE = 3'd5;
	localparam logic [STATUS_W-1:0] ST_FULL              = 3'd6;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_POP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_HEAD_WR,
		S_DONE
	} state_t;

endpackage

FILE: hdl/lsm_ram.sv
// ----------------------------------------------------------------------------
// LRU slot manager RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lsm_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/lru_slot_manager_pinned_root_core.sv
// ----------------------------------------------------------------------------
// LRU slot manager with pinned root
// Keeps a most-recent-first list of used slots and a LIFO pool of free slots.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one command per transaction (insert root,
//   allocate, touch, release, lookup) with a slot operand. The master stream
//   returns one result per command: status, granted slot, evicted slot and
//   recency rank. Only one command is in work at a time; s_tready is high
//   while the sequencer is idle, also while a result waits on the master side.
//   Sequence: every command passes from idle through decode to done; insert
//   root adds a head write. A search or reorder of the recency list walks it
//   one entry at a time, a read then a compare or a write per entry, since the
//   list lives in a RAM with one write and one registered read port: a touch
//   scans up to its rank, shifts the more recent entries down and writes the
//   head; allocation from a non-empty pool pops, shifts the list and writes it.
//   Reset: empty list, pool holds slots 2 upward with 2 on top; ready at once.
//   Stall: a result holds on m_tdata until taken; the next command can be
//   accepted and worked, but finishes only once the output register is free.
// ----------------------------------------------------------------------------
`include "lru_slot_manager_pinned_root_core_defines.svh"

module lru_slot_manager_pinned_root_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [2:0] command, [7:3] slot
	input  logic [lsm_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [2:0] status, [7:3] slot_out, [8] evicted_valid, [13:9] evicted_slot,
	// [18:14] recency_rank, [23:19] zero
	output logic [lsm_pkg::OUT_DATA_W-1:0] m_tdata
);

	import lsm_pkg::*;

	state_t state_q, state_d;

	// Command registers
	logic [CMD_W-1:0]    cmd_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                evict_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [SLOT_W-1:0]   head_q;

	// Pool bookkeeping
	logic [COUNT_W-1:0]  count_q;
	logic [COUNT_W-1:0]  fc_q;
	logic [COUNT_W-1:0]  lw_q;

	// Result being built and result on the output
	logic [STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic                res_ev_valid_q;
	logic [SLOT_W-1:0]   res_ev_slot_q;
	logic [SLOT_W-1:0]   res_rank_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic                out_ev_valid_q;
	logic [SLOT_W-1:0]   out_ev_slot_q;
	logic [SLOT_W-1:0]   out_rank_q;
	logic                out_valid_q;

	// RAM ports
	logic                ord_we;
	logic [SLOT_W-1:0]   ord_waddr;
	logic [SLOT_W-1:0]   ord_wdata;
	logic [SLOT_W-1:0]   ord_raddr;
	logic [SLOT_W-1:0]   ord_rdata;
	logic                stk_we;
	logic [SLOT_W-1:0]   stk_waddr;
	logic [SLOT_W-1:0]   stk_wdata;
	logic [SLOT_W-1:0]   stk_raddr;
	logic [SLOT_W-1:0]   stk_rdata;

	// Shared index stepper and compare unit
	logic                step_up;
	logic [SLOT_W-1:0]   idx_step;
	logic [SLOT_W-1:0]   cmp_key;
	logic                cmp_eq;
	logic                scan_hit;
	logic                scan_last;
	logic [COUNT_W-1:0]  count_m1;
	logic [COUNT_W-1:0]  pop_idx;
	logic [SLOT_W-1:0]   pop_slot;
	logic                out_free;

	// Decode results
	state_t              dec_next;
	logic [STATUS_W-1:0] dec_status;
	logic [SLOT_W-1:0]   dec_idx;
	logic                dec_evict;

	// Storage
	lsm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_order_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.raddr (ord_raddr),
		.rdata (ord_rdata)
	);

	lsm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_free_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Step the index: search up for touch, release and lookup, shift up for
	// release; search and shift down for eviction and insertion at the head
	assign step_up  = !evict_q && (state_q == S_SCAN_CMP || cmd_q == CMD_RELEASE);
	assign idx_step = step_up ? idx_q + SLOT_W'(1) : idx_q - SLOT_W'(1);

	// Compare list entry against the operand, or against the root for eviction
	assign cmp_key   = evict_q ? ROOT_SLOT : slot_q;
	assign cmp_eq    = (ord_rdata == cmp_key);
	assign scan_hit  = evict_q ? !cmp_eq : cmp_eq;
	assign scan_last = evict_q ? (idx_q == '0)
	                           : (({1'b0, idx_q} + COUNT_W'(1)) >= count_q);

	// Pool top; entries below the low watermark were never written, so their reset contents come from the index
	assign count_m1 = count_q - COUNT_W'(1);
	assign pop_idx  = fc_q - COUNT_W'(1);
	assign pop_slot = (pop_idx < lw_q) ? SLOT_W'(SLOT_COUNT - 1) - pop_idx[SLOT_W-1:0]
	                                   : stk_rdata;

	assign out_free = !out_valid_q || m_tready;

	// Decode the command against the counters
	always_comb begin
		dec_next   = S_DONE;
		dec_status = ST_NOT_FOUND;
		dec_idx    = '0;
		dec_evict  = 1'b0;
		case (cmd_q)
			CMD_INSERT_ROOT: begin
				if (count_q != '0) begin
					dec_status = ST_NOT_EMPTY;
				end else begin
					dec_status = ST_OK;
					dec_next   = S_HEAD_WR;
				end
			end
			CMD_ALLOCATE: begin
				if (count_q == '0) begin
					dec_status = ST_NO_ROOT;
				end else if (count_q >= COUNT_W'(SLOT_COUNT)) begin
					dec_status = ST_FULL;
				end else if (fc_q == '0) begin
					dec_status = ST_FULL;
					dec_evict  = 1'b1;
					dec_idx    = count_m1[SLOT_W-1:0];
					dec_next   = S_SCAN_RD;
				end else begin
					dec_status = ST_OK;
					dec_idx    = count_q[SLOT_W-1:0];
					dec_next   = S_POP;
				end
			end
			CMD_TOUCH: begin
				if (slot_q == ROOT_SLOT) begin
					dec_status = ST_OK;
				end else if (count_q != '0) begin
					dec_next = S_SCAN_RD;
				end
			end
			CMD_RELEASE: begin
				if (slot_q == RESERVED_SLOT) begin
					dec_status = ST_NOTHING_TO_DELETE;
				end else if (slot_q == ROOT_SLOT) begin
					dec_status = ST_ROOT_PROTECTED;
				end else begin
					dec_status = ST_NOTHING_TO_DELETE;
					if (count_q != '0) begin
						dec_next = S_SCAN_RD;
					end
				end
			end
			CMD_LOOKUP: begin
				if (count_q != '0) begin
					dec_next = S_SCAN_RD;
				end
			end
			default: begin
				dec_status = ST_NOT_FOUND;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = dec_next;
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (scan_hit) begin
					if (evict_q || cmd_q == CMD_TOUCH) begin
						state_d = (idx_q == '0) ? S_HEAD_WR : S_SHIFT_RD;
					end else if (cmd_q == CMD_RELEASE) begin
						state_d = scan_last ? S_DONE : S_SHIFT_RD;
					end else begin
						state_d = S_DONE;
					end
				end else if (scan_last) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_POP: begin
				state_d = S_SHIFT_RD;
			end
			S_SHIFT_RD: begin
				state_d = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				if (step_up) begin
					state_d = ({1'b0, idx_step} < count_q) ? S_SHIFT_RD : S_DONE;
				end else begin
					state_d = (idx_q == SLOT_W'(1)) ? S_HEAD_WR : S_SHIFT_RD;
				end
			end
			S_HEAD_WR: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Handshake and RAM controls
	always_comb begin
		s_tready  = (state_q == S_IDLE);
		ord_raddr = (state_q == S_SHIFT_RD) ? idx_step : idx_q;
		ord_we    = (state_q == S_SHIFT_WR) || (state_q == S_HEAD_WR);
		ord_waddr = (state_q == S_HEAD_WR) ? '0 : idx_q;
		ord_wdata = (state_q == S_HEAD_WR) ? head_q : ord_rdata;
		stk_raddr = pop_idx[SLOT_W-1:0];
		stk_we    = (state_q == S_SCAN_CMP) && (cmd_q == CMD_RELEASE) && !evict_q
		            && scan_hit && (fc_q < COUNT_W'(SLOT_COUNT));
		stk_waddr = fc_q[SLOT_W-1:0];
		stk_wdata = slot_q;
	end

	// Control state: sequencer, counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			fc_q        <= COUNT_W'(SLOT_COUNT - 2);
			lw_q        <= COUNT_W'(SLOT_COUNT - 2);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Root enters an empty list
			if (state_q == S_DECODE && cmd_q == CMD_INSERT_ROOT && count_q == '0) begin
				count_q <= COUNT_W'(1);
			end
			// Released slot leaves the list
			if (state_q == S_SCAN_CMP && cmd_q == CMD_RELEASE && !evict_q && scan_hit) begin
				count_q <= count_m1;
			end
			if (stk_we) begin
				fc_q <= fc_q + COUNT_W'(1);
			end
			// Pop the pool top into the list
			if (state_q == S_POP) begin
				count_q <= count_q + COUNT_W'(1);
				fc_q    <= pop_idx;
				if (pop_idx < lw_q) begin
					lw_q <= pop_idx;
				end
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: command, index, result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd_q  <= s_tdata[CMD_W-1:0];
					slot_q <= s_tdata[CMD_W +: SLOT_W];
				end
			end
			S_DECODE: begin
				evict_q        <= dec_evict;
				idx_q          <= dec_idx;
				head_q         <= (cmd_q == CMD_INSERT_ROOT) ? ROOT_SLOT : slot_q;
				res_status_q   <= dec_status;
				res_slot_q     <= (cmd_q == CMD_INSERT_ROOT && count_q == '0) ? ROOT_SLOT : '0;
				res_ev_valid_q <= 1'b0;
				res_ev_slot_q  <= '0;
				res_rank_q     <= '0;
			end
			S_SCAN_CMP: begin
				if (scan_hit) begin
					res_status_q <= ST_OK;
					if (evict_q) begin
						res_ev_valid_q <= 1'b1;
						res_ev_slot_q  <= ord_rdata;
						res_slot_q     <= ord_rdata;
						head_q         <= ord_rdata;
					end
					if (cmd_q == CMD_LOOKUP) begin
						res_rank_q <= idx_q;
					end
				end else if (!scan_last) begin
					idx_q <= idx_step;
				end
			end
			S_POP: begin
				res_slot_q <= pop_slot;
				head_q     <= pop_slot;
			end
			S_SHIFT_WR: begin
				idx_q <= idx_step;
			end
			S_DONE: begin
				if (out_free) begin
					out_status_q   <= res_status_q;
					out_slot_q     <= res_slot_q;
					out_ev_valid_q <= res_ev_valid_q;
					out_ev_slot_q  <= res_ev_slot_q;
					out_rank_q     <= res_rank_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_rank_q, out_ev_slot_q, out_ev_valid_q,
	                   out_slot_q, out_status_q};

	// Listed and pooled slots together never exceed the slots but the reserved one
	`LSM_ASSERT(a_slot_conservation, clk, arst_n, ({1'b0, count_q} + {1'b0, fc_q}) <= (COUNT_W + 1)'(SLOT_COUNT - 1), "slot leaked or duplicated between list and pool")
	// Pool low watermark never lies above the pool depth
	`LSM_ASSERT(a_watermark_bound, clk, arst_n, lw_q <= fc_q, "pool watermark above pool depth")
	// An accepted command blocks the next one until it is worked
	`LSM_ASSERT_NEXT(a_one_in_work, clk, arst_n, s_tvalid && s_tready, !s_tready, "second command accepted while one is in work")

endmodule
